>>> rtl/core/clu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clu_pkg: shared types and helpers for the card number Luhn classifier
// Widths of the binary and BCD words, the pipeline beat structures, the card
// type codes and the small digit functions used by the tail stages.
// ----------------------------------------------------------------------------
package clu_pkg;

	localparam int CardNumW  = 54;
	localparam int NumDigits = 17;
	localparam int BcdW      = 4 * NumDigits;

	typedef enum logic [1:0] {
		CT_NONE    = 2'd0,
		CT_LEAD4   = 2'd1,
		CT_LEAD3X  = 2'd2,
		CT_LEAD5X  = 2'd3
	} card_type_t;

	// One beat travelling down the conversion chain
	typedef struct packed {
		logic                vld;
		logic [BcdW-1:0]     bcd;
		logic [CardNumW-1:0] bin;
	} dd_beat_t;

	// One finished result leaving the tail
	typedef struct packed {
		logic       vld;
		card_type_t ctype;
		logic       ok;
	} res_beat_t;

	// Luhn contribution of one decimal digit; doubled digits fold above nine
	function automatic logic [3:0] luhn_digit(input logic [3:0] d, input logic dbl);
		logic [4:0] t;
		logic [3:0] r;
		t = {d, 1'b0};
		if (!dbl) begin
			r = d;
		end else if (t > 5'd9) begin
			r = 4'(t - 5'd9);
		end else begin
			r = t[3:0];
		end
		return r;
	endfunction

	// True when a digit sum (at most 153) is a multiple of ten
	function automatic logic is_mult10(input logic [7:0] s);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < 16; k++) begin
			if (s == 8'(10 * k)) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

>>> rtl/core/clu_dd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clu_dd_cell: one shift-and-add-3 cell of the binary to BCD chain
// Corrects every BCD digit of five or more by three, then shifts the top bit
// of the remaining binary word into the BCD word. Registered output.
// ----------------------------------------------------------------------------
module clu_dd_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  clu_pkg::dd_beat_t in_beat,
	output clu_pkg::dd_beat_t out_beat
);
	import clu_pkg::*;

	logic [BcdW-1:0]     adj;
	logic [BcdW-1:0]     bcd_q;
	logic [CardNumW-1:0] bin_q;
	logic                vld_q;

	always_comb begin
		adj = in_beat.bcd;
		for (int i = 0; i < NumDigits; i++) begin
			if (in_beat.bcd[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = in_beat.bcd[4*i +: 4] + 4'd3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_beat.vld;
		end
	end

	// the top BCD bit dropped here is always zero for a 54-bit input
	always_ff @(posedge clk) begin
		if (en) begin
			bcd_q <= {adj[BcdW-2:0], in_beat.bin[CardNumW-1]};
			bin_q <= {in_beat.bin[CardNumW-2:0], 1'b0};
		end
	end

	assign out_beat = '{vld: vld_q, bcd: bcd_q, bin: bin_q};

endmodule

>>> rtl/core/clu_luhn_tail.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clu_luhn_tail: Luhn sum and length/prefix classification
// Stage one maps the digits and forms group sums and the class candidate;
// stage two closes the sum, checks it mod ten and gates the class.
// ----------------------------------------------------------------------------
module clu_luhn_tail (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vld,
	input  logic [clu_pkg::BcdW-1:0] bcd,
	output clu_pkg::res_beat_t res
);
	import clu_pkg::*;

	localparam int NumGroups = 5;

	logic [3:0] dig [NumDigits];
	logic [3:0] mapd [NumDigits];
	logic [5:0] gsum [NumGroups];
	card_type_t cls;
	logic       z16;
	logic       len13;
	logic       len15;
	logic       len16;

	logic       vld_s1;
	logic [5:0] gsum_s1 [NumGroups];
	card_type_t cls_s1;

	logic [7:0] total;
	logic       vld_s2;
	logic       ok_s2;
	card_type_t ctype_s2;

	always_comb begin
		for (int i = 0; i < NumDigits; i++) begin
			dig[i]  = bcd[4*i +: 4];
			mapd[i] = luhn_digit(dig[i], i[0]);
		end
		for (int g = 0; g < NumGroups - 1; g++) begin
			gsum[g] = 6'(mapd[4*g]) + 6'(mapd[4*g+1]) + 6'(mapd[4*g+2]) + 6'(mapd[4*g+3]);
		end
		gsum[NumGroups-1] = 6'(mapd[NumDigits-1]);
	end

	// digit count from the highest non-zero digit
	always_comb begin
		z16   = (dig[16] == 4'd0);
		len16 = z16 && (dig[15] != 4'd0);
		len15 = z16 && (dig[15] == 4'd0) && (dig[14] != 4'd0);
		len13 = z16 && (dig[15] == 4'd0) && (dig[14] == 4'd0) && (dig[13] == 4'd0)
			&& (dig[12] != 4'd0);
		priority if (len13 && (dig[12] == 4'd4)) begin
			cls = CT_LEAD4;
		end else if (len15 && (dig[14] == 4'd3) && ((dig[13] == 4'd4) || (dig[13] == 4'd7))) begin
			cls = CT_LEAD3X;
		end else if (len16 && (dig[15] == 4'd5) && (dig[14] >= 4'd1) && (dig[14] <= 4'd5)) begin
			cls = CT_LEAD5X;
		end else if (len16 && (dig[15] == 4'd4)) begin
			cls = CT_LEAD4;
		end else begin
			cls = CT_NONE;
		end
	end

	always_comb begin
		total = '0;
		for (int g = 0; g < NumGroups; g++) begin
			total = total + 8'(gsum_s1[g]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gsum_s1  <= gsum;
			cls_s1   <= cls;
			ok_s2    <= is_mult10(total);
			ctype_s2 <= is_mult10(total) ? cls_s1 : CT_NONE;
		end
	end

	assign res = '{vld: vld_s2, ctype: ctype_s2, ok: ok_s2};

endmodule

>>> rtl/core/card_number_luhn_classify_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// card_number_luhn_classify_unit: Luhn mod-10 check and card classification
//
//   beat    | ports                                   | dir
//   --------+-----------------------------------------+-----
//   number  | card_valid, card_stall, card_number     | in
//   result  | result_valid, result_stall, card_type,  | out
//           | luhn_ok                                 |
//
// One number per cycle while card_stall is low. The pipe is 54 shift-and-add-3
// cells (one per input bit), two Luhn/classify stages and the output register.
// Reset clears every valid flag; no clearing pass is needed.
// A stalled result parks one beat in the skid register; card_stall is that
// register's full flag, and the whole pipe holds while it is set.
// ----------------------------------------------------------------------------
module card_number_luhn_classify_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          card_valid,
	output logic                          card_stall,
	input  logic [clu_pkg::CardNumW-1:0]  card_number,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [1:0]                    card_type,
	output logic                          luhn_ok
);
	import clu_pkg::*;

	dd_beat_t   chain [CardNumW+1];
	res_beat_t  res;
	logic       en;

	logic       out_valid_q;
	card_type_t out_type_q;
	logic       out_ok_q;
	logic       skid_valid_q;
	card_type_t skid_type_q;
	logic       skid_ok_q;
	logic       out_free;

	assign en         = !skid_valid_q;
	assign card_stall = skid_valid_q;
	assign out_free   = !out_valid_q || !result_stall;

	assign chain[0] = '{vld: card_valid, bcd: '0, bin: card_number};

	for (genvar c = 0; c < CardNumW; c++) begin : g_cell
		clu_dd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_beat  (chain[c]),
			.out_beat (chain[c+1])
		);
	end

	clu_luhn_tail u_tail (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld    (chain[CardNumW].vld),
		.bcd    (chain[CardNumW].bcd),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= en && res.vld;
			end
		end else if (en && res.vld) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_type_q <= skid_type_q;
				out_ok_q   <= skid_ok_q;
			end else begin
				out_type_q <= res.ctype;
				out_ok_q   <= res.ok;
			end
		end else if (en && res.vld) begin
			skid_type_q <= res.ctype;
			skid_ok_q   <= res.ok;
		end
	end

	assign result_valid = out_valid_q;
	assign card_type    = out_type_q;
	assign luhn_ok      = out_ok_q;

	// a parked beat always has a beat ahead of it in the output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a beat while the output register is empty");

	// the skid only fills while the output is held
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && result_stall))
		else $error("skid filled while the output was free");

	// drain the skid as soon as the output moves
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !result_stall |=> !skid_valid_q)
		else $error("skid did not drain after the output beat moved");

	// a failed Luhn sum never carries a card class
	a_type_gated: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (luhn_ok || (card_type == CT_NONE)))
		else $error("card class reported with a failed Luhn sum");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: checker for the card number Luhn classifier
// Directed numbers at the length, prefix and range edges are followed by
// random well-formed card numbers, near misses and raw 54-bit noise. Each
// accepted number is scored by a local Luhn and prefix model, and every
// result beat is compared in order. Both sides idle and stall in bursts.
// ----------------------------------------------------------------------------
module tb_top;
	import clu_pkg::*;

	typedef struct packed {
		card_type_t ctype;
		logic       ok;
	} verdict_t;

	localparam longint unsigned NumMask = 64'h003F_FFFF_FFFF_FFFF;
	localparam longint unsigned E10 = 64'd10000000000;
	localparam longint unsigned E11 = 64'd100000000000;
	localparam longint unsigned E12 = 64'd1000000000000;
	localparam longint unsigned E13 = 64'd10000000000000;
	localparam longint unsigned E14 = 64'd100000000000000;
	localparam longint unsigned E15 = 64'd1000000000000000;
	localparam longint unsigned E16 = 64'd10000000000000000;
	localparam int RandomNumbers = 500;
	localparam int CalmTail      = 60;
	localparam int DrainCycles   = 80;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                card_valid   = 1'b0;
	logic                card_stall;
	logic [CardNumW-1:0] card_number  = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	logic [1:0]          card_type;
	logic                luhn_ok;

	longint unsigned numbers_to_send[$];
	verdict_t        expected_verdicts[$];
	int              errors      = 0;
	int              send_gap    = 0;
	int              send_idle   = 10;
	int              stall_left  = 0;
	int              stall_pct   = 10;

	card_number_luhn_classify_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.card_valid   (card_valid),
		.card_stall   (card_stall),
		.card_number  (card_number),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.card_type    (card_type),
		.luhn_ok      (luhn_ok)
	);

	always #5 clk = ~clk;

	function automatic longint unsigned pow10(input int k);
		longint unsigned r;
		r = 1;
		for (int i = 0; i < k; i++) begin
			r = r * 10;
		end
		return r;
	endfunction

	function automatic longint unsigned rand_below(input longint unsigned lim);
		longint unsigned r;
		r = {$urandom, $urandom};
		return r % lim;
	endfunction

	function automatic bit luhn_sum_ok(input longint unsigned n);
		int unsigned sum;
		int unsigned pos;
		int unsigned d;
		sum = 0;
		pos = 0;
		while (n != 0) begin
			d = int'(n % 10);
			n = n / 10;
			if (pos % 2 == 1) begin
				d = d * 2;
				if (d > 9) begin
					d = d - 9;
				end
			end
			sum += d;
			pos++;
		end
		return (sum % 10) == 0;
	endfunction

	function automatic verdict_t card_verdict(input longint unsigned n);
		verdict_t        v;
		longint unsigned p;
		v.ok    = luhn_sum_ok(n);
		v.ctype = CT_NONE;
		if (v.ok) begin
			if (n >= E12 && n < E13) begin
				if (n / E12 == 4) begin
					v.ctype = CT_LEAD4;
				end
			end else if (n >= E14 && n < E15) begin
				p = n / E13;
				if (p == 34 || p == 37) begin
					v.ctype = CT_LEAD3X;
				end
			end else if (n >= E15 && n < E16) begin
				p = n / E14;
				if (p >= 51 && p <= 55) begin
					v.ctype = CT_LEAD5X;
				end else if (p / 10 == 4) begin
					v.ctype = CT_LEAD4;
				end
			end
		end
		return v;
	endfunction

	// Append the digit that makes the Luhn sum a multiple of ten
	function automatic longint unsigned with_check(input longint unsigned base);
		longint unsigned cand;
		cand = base * 10;
		for (int c = 0; c < 10; c++) begin
			if (luhn_sum_ok(base * 10 + c)) begin
				cand = base * 10 + c;
				break;
			end
		end
		return cand;
	endfunction

	// Number of digits total with the given leading digits and a valid check digit
	function automatic longint unsigned card_with_prefix(input longint unsigned prefix,
			input int plen, input int total);
		int rest;
		rest = total - 1 - plen;
		return with_check(prefix * pow10(rest) + rand_below(pow10(rest)));
	endfunction

	// Sender: hold a stalled beat, otherwise idle a burst or present the next number
	always @(posedge clk) begin
		if (!arst_n) begin
			card_valid <= 1'b0;
		end else if (!card_valid || !card_stall) begin
			if ($urandom_range(0, 63) == 0) begin
				send_idle = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
			end
			if (send_gap != 0) begin
				send_gap   = send_gap - 1;
				card_valid <= 1'b0;
			end else if (numbers_to_send.size() > CalmTail &&
					$urandom_range(0, 99) < send_idle) begin
				send_gap   = $urandom_range(1, 18) - 1;
				card_valid <= 1'b0;
			end else if (numbers_to_send.size() != 0) begin
				card_number <= CardNumW'(numbers_to_send.pop_front());
				card_valid  <= 1'b1;
			end else begin
				card_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall in bursts until the calm tail of the run
	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0) begin
			stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
		end
		if (stall_left != 0) begin
			stall_left   = stall_left - 1;
			result_stall <= 1'b1;
		end else if (numbers_to_send.size() > CalmTail &&
				$urandom_range(0, 99) < stall_pct) begin
			stall_left   = $urandom_range(1, 18) - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// Score accepted numbers and check result beats in order
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n) begin
			if (card_valid && !card_stall) begin
				expected_verdicts.push_back(card_verdict(64'(card_number)));
			end
			if (result_valid && !result_stall) begin
				if (expected_verdicts.size() == 0) begin
					$error("unexpected result beat: card_type %0d, luhn_ok %0d",
						card_type, luhn_ok);
					errors++;
				end else begin
					want = expected_verdicts.pop_front();
					if (card_type !== want.ctype) begin
						$error("card_type: expected %0d, actual %0d", want.ctype, card_type);
						errors++;
					end
					if (luhn_ok !== want.ok) begin
						$error("luhn_ok: expected %0d, actual %0d", want.ok, luhn_ok);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		longint unsigned n;
		longint unsigned prefix;
		int              sel;
		int              digits;

		// Edges of range, length and prefix
		numbers_to_send.push_back(64'd0);
		numbers_to_send.push_back(NumMask);
		numbers_to_send.push_back(E16 - 1);
		numbers_to_send.push_back(E16);
		numbers_to_send.push_back(with_check(E15));
		numbers_to_send.push_back(with_check(4 * E11));
		numbers_to_send.push_back(with_check(4 * E11) ^ 64'd1);
		numbers_to_send.push_back(with_check(39 * E10));
		numbers_to_send.push_back(with_check(4 * E10));
		numbers_to_send.push_back(with_check(4 * E12));
		numbers_to_send.push_back(with_check(34 * E12));
		numbers_to_send.push_back(with_check(37 * E12 + E12 - 1));
		numbers_to_send.push_back(with_check(35 * E12));
		numbers_to_send.push_back(with_check(34 * E11));
		numbers_to_send.push_back(with_check(51 * E13));
		numbers_to_send.push_back(with_check(55 * E13 + E13 - 1));
		numbers_to_send.push_back(with_check(50 * E13 + E13 - 1));
		numbers_to_send.push_back(with_check(56 * E13));
		numbers_to_send.push_back(with_check(4 * E14));
		numbers_to_send.push_back(with_check(4 * E14 + E14 - 1));
		numbers_to_send.push_back(with_check(4 * E14) ^ 64'd1);
		numbers_to_send.push_back(with_check(52 * E13) ^ 64'd1);
		numbers_to_send.push_back(64'd5);
		numbers_to_send.push_back(64'd18);

		for (int i = 0; i < RandomNumbers; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 65) begin
				case ($urandom_range(0, 3))
					0: n = card_with_prefix(4, 1, 13);
					1: n = card_with_prefix($urandom_range(0, 1) ? 34 : 37, 2, 15);
					2: n = card_with_prefix($urandom_range(51, 55), 2, 16);
					default: n = card_with_prefix(4, 1, 16);
				endcase
				// break the check digit on some well-formed numbers
				if (sel >= 55) begin
					n = n ^ 64'd1;
				end
			end else if (sel < 85) begin
				prefix = $urandom_range(10, 99);
				digits = $urandom_range(11, 17);
				n      = card_with_prefix(prefix, 2, digits) & NumMask;
			end else if (sel < 93) begin
				n = {$urandom, $urandom};
				n = n & NumMask;
			end else begin
				n = rand_below(pow10($urandom_range(1, 17))) & NumMask;
			end
			numbers_to_send.push_back(n);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (numbers_to_send.size() != 0 || card_valid) begin
			@(posedge clk);
		end
		while (expected_verdicts.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
